// ===== src/sll_pkg.sv =====
// Shared definitions for the array-based linked list engine.
// Holds command and status codes and the fixed field widths; no dependencies.
`timescale 1ns / 1ps

package sll_pkg;

  // Fixed field widths of the command and result ports.
  localparam int unsigned POS_W    = 7;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 3;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_INS_HEAD  = 2'd0,
    CMD_INS_AFTER = 2'd1,
    CMD_DEL_AFTER = 2'd2,
    CMD_READ      = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_BADPOS = 3'd2,
    ST_NOSUCC = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

endpackage

// ===== src/sll_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the value and link stores of the list engine; no dependencies.
`timescale 1ns / 1ps

module sll_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/static_linked_list_engine_top.sv =====
// Top level of the array-based singly linked list engine.
// Depends on sll_pkg and on sll_ram for the value and link stores.
`timescale 1ns / 1ps

// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   command selects insert at head, insert after the k-th inserted node,
//   delete after the k-th inserted node (position 0 deletes the head), or
//   read of the whole list.
//   Each result shows on value_out, status and last for exactly one cycle,
//   marked by result_valid. The receiver cannot stall; results are never held.
//   Steps per command:
//     insert at head and errors found at decode (full, bad position, empty):
//       the result is registered and the next request may follow in the next cycle.
//     insert after: link read, new-node link write, reference write.
//     delete at head: head link read, then head update; delete after a node:
//       reference link read, then, with a successor, its link read and the reference write.
//     read: one result per cycle, the first once the head node has been read;
//       the walk is set by the single link memory read port, one node a cycle.
//   Reset clears the head pointer to the null marker and the node count to
//   zero. The memories are not cleared; only written slots are ever reached.
module static_linked_list_engine_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  command,
  input  logic [sll_pkg::POS_W-1:0]   position,
  input  logic signed [sll_pkg::DATA_W-1:0] value_in,
  output logic                        result_valid,
  output logic signed [sll_pkg::DATA_W-1:0] value_out,
  output logic [sll_pkg::STATUS_W-1:0] status,
  output logic                        last
);

  import sll_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NIL_LINK = LW'(CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_INS_W1   = 7'b0000010,
    S_INS_W2   = 7'b0000100,
    S_DEL_HEAD = 7'b0001000,
    S_DEL_R1   = 7'b0010000,
    S_DEL_R2   = 7'b0100000,
    S_WALK     = 7'b1000000
  } state_t;

  state_t            state, state_next;
  logic [LW-1:0]     head_index, head_index_next;
  logic [LW-1:0]     used_count, used_count_next;
  logic [AW-1:0]     ref_slot, ref_slot_next;
  logic [DATA_W-1:0] value_hold, value_hold_next;
  logic [LW-1:0]     walk_count, walk_count_next;
  logic              result_valid_next;
  logic [DATA_W-1:0] value_out_next;
  logic [STATUS_W-1:0] status_next;
  logic              last_next;

  // Memory port signals.
  logic              link_we, val_we;
  logic [AW-1:0]     link_waddr, val_waddr, rd_addr;
  logic [LW-1:0]     link_wdata, link_rdata;
  logic [DATA_W-1:0] val_wdata, val_rdata;

  logic [POS_W-1:0]  pos_m1;
  logic [POS_W-1:0]  used_ext;
  logic              list_full;
  logic              walk_fin;

  function automatic logic slot_ok(input logic [LW-1:0] s);
    return s < NIL_LINK;
  endfunction

  sll_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_values (
    .clk  (clk),
    .we   (val_we),
    .waddr(val_waddr),
    .wdata(val_wdata),
    .raddr(rd_addr),
    .rdata(val_rdata)
  );

  sll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_links (
    .clk  (clk),
    .we   (link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .raddr(rd_addr),
    .rdata(link_rdata)
  );

  assign busy     = (state != S_IDLE);
  assign pos_m1   = position - POS_W'(1);
  assign used_ext = POS_W'(used_count);
  assign list_full = (used_count == NIL_LINK);
  assign walk_fin = !slot_ok(link_rdata) || ((walk_count + LW'(1)) >= NIL_LINK);

  // Command sequencer: decode, memory reads, write-back and result formation.
  always_comb begin
    state_next        = state;
    head_index_next   = head_index;
    used_count_next   = used_count;
    ref_slot_next     = ref_slot;
    value_hold_next   = value_hold;
    walk_count_next   = walk_count;
    result_valid_next = 1'b0;
    value_out_next    = '0;
    status_next       = ST_OK;
    last_next         = 1'b1;
    link_we           = 1'b0;
    val_we            = 1'b0;
    link_waddr        = used_count[AW-1:0];
    val_waddr         = used_count[AW-1:0];
    link_wdata        = head_index;
    val_wdata         = value_in;
    rd_addr           = head_index[AW-1:0];

    case (state)
      S_IDLE: begin
        if (start) begin
          ref_slot_next   = pos_m1[AW-1:0];
          value_hold_next = value_in;
          case (cmd_t'(command))
            CMD_INS_HEAD: begin
              result_valid_next = 1'b1;
              if (list_full) begin
                status_next = ST_FULL;
              end else begin
                val_we          = 1'b1;
                link_we         = 1'b1;
                head_index_next = used_count;
                used_count_next = used_count + LW'(1);
              end
            end
            CMD_INS_AFTER: begin
              if (list_full) begin
                result_valid_next = 1'b1;
                status_next       = ST_FULL;
              end else if (position == '0 || position > used_ext) begin
                result_valid_next = 1'b1;
                status_next       = ST_BADPOS;
              end else begin
                rd_addr    = pos_m1[AW-1:0];
                state_next = S_INS_W1;
              end
            end
            CMD_DEL_AFTER: begin
              if (position > used_ext) begin
                result_valid_next = 1'b1;
                status_next       = ST_BADPOS;
              end else if (position == '0) begin
                if (!slot_ok(head_index)) begin
                  result_valid_next = 1'b1;
                  status_next       = ST_EMPTY;
                end else begin
                  state_next = S_DEL_HEAD;
                end
              end else begin
                rd_addr    = pos_m1[AW-1:0];
                state_next = S_DEL_R1;
              end
            end
            CMD_READ: begin
              if (!slot_ok(head_index)) begin
                result_valid_next = 1'b1;
                status_next       = ST_EMPTY;
              end else begin
                walk_count_next = '0;
                state_next      = S_WALK;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      // New node takes over the reference node's successor.
      S_INS_W1: begin
        link_we    = 1'b1;
        link_wdata = link_rdata;
        val_we     = 1'b1;
        val_wdata  = value_hold;
        state_next = S_INS_W2;
      end

      // Reference node now points at the new node.
      S_INS_W2: begin
        link_we           = 1'b1;
        link_waddr        = ref_slot;
        link_wdata        = used_count;
        used_count_next   = used_count + LW'(1);
        result_valid_next = 1'b1;
        state_next        = S_IDLE;
      end

      S_DEL_HEAD: begin
        head_index_next   = link_rdata;
        result_valid_next = 1'b1;
        state_next        = S_IDLE;
      end

      // Successor of the reference node is known; fetch its link.
      S_DEL_R1: begin
        if (!slot_ok(link_rdata)) begin
          result_valid_next = 1'b1;
          status_next       = ST_NOSUCC;
          state_next        = S_IDLE;
        end else begin
          rd_addr    = link_rdata[AW-1:0];
          state_next = S_DEL_R2;
        end
      end

      S_DEL_R2: begin
        link_we           = 1'b1;
        link_waddr        = ref_slot;
        link_wdata        = link_rdata;
        result_valid_next = 1'b1;
        state_next        = S_IDLE;
      end

      // One node per cycle: emit its value and read the next one.
      S_WALK: begin
        result_valid_next = 1'b1;
        value_out_next    = val_rdata;
        last_next         = walk_fin;
        if (walk_fin) begin
          state_next = S_IDLE;
        end else begin
          rd_addr         = link_rdata[AW-1:0];
          walk_count_next = walk_count + LW'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state with synchronous reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head_index   <= NIL_LINK;
      used_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      head_index   <= head_index_next;
      used_count   <= used_count_next;
      result_valid <= result_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ref_slot   <= ref_slot_next;
    value_hold <= value_hold_next;
    walk_count <= walk_count_next;
    value_out  <= value_out_next;
    status     <= status_next;
    last       <= last_next;
  end

  // A request that is taken either answers at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (result_valid || busy))
    else $error("accepted request produced neither a result nor work");

  // Only a list read gives results that are not the final one.
  a_nonlast_in_walk: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> (state == S_WALK))
    else $error("non-final result outside a list read");

  // The node count never passes the capacity.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= NIL_LINK)
    else $error("node count beyond capacity");

  // The head is always a slot already handed out, or null.
  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    (head_index == NIL_LINK) || (head_index < used_count))
    else $error("head points at an unused slot");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the array-based singly linked list engine.
// Depends on sll_pkg and static_linked_list_engine_top; a scoreboard mirrors the list.
`timescale 1ns / 1ps

module testbench;
  import sll_pkg::*;

  localparam int unsigned CAPACITY       = 64;
  localparam int unsigned NULL_SLOT      = CAPACITY;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 10;

  // One result as the engine should emit it.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
    logic                     last;
  } list_result_t;

  // Mirror of the list storage and the queue of results still owed by the engine.
  class linked_list_scoreboard;
    logic signed [DATA_W-1:0] slot_value [CAPACITY];
    logic [POS_W-1:0]         slot_link  [CAPACITY];
    int unsigned              head_slot;
    int unsigned              slot_count;
    list_result_t             pending_results [$];
    int unsigned              mismatch_count;

    function new();
      head_slot      = NULL_SLOT;
      slot_count     = 0;
      mismatch_count = 0;
    endfunction

    function void owe_result(logic signed [DATA_W-1:0] value, status_t st, logic lst);
      list_result_t r;
      r.value  = value;
      r.status = st;
      r.last   = lst;
      pending_results.push_back(r);
    endfunction

    // Update the mirror for an accepted request and queue the results it causes.
    function void apply_request(cmd_t cmd, logic [POS_W-1:0] pos,
                                logic signed [DATA_W-1:0] val);
      status_t     st;
      int unsigned ref_slot;
      int unsigned succ;
      int unsigned cur;
      int unsigned walked;
      st = ST_OK;
      case (cmd)
        CMD_INS_HEAD: begin
          if (slot_count >= CAPACITY) begin
            st = ST_FULL;
          end else begin
            slot_value[slot_count] = val;
            slot_link[slot_count]  = head_slot[POS_W-1:0];
            head_slot              = slot_count;
            slot_count++;
          end
        end
        CMD_INS_AFTER: begin
          if (slot_count >= CAPACITY) begin
            st = ST_FULL;
          end else if (pos == 0 || pos > slot_count) begin
            st = ST_BADPOS;
          end else begin
            ref_slot               = pos - 1;
            slot_value[slot_count] = val;
            slot_link[slot_count]  = slot_link[ref_slot];
            slot_link[ref_slot]    = slot_count[POS_W-1:0];
            slot_count++;
          end
        end
        CMD_DEL_AFTER: begin
          if (pos > slot_count) begin
            st = ST_BADPOS;
          end else if (pos == 0) begin
            if (head_slot >= CAPACITY) st = ST_EMPTY;
            else head_slot = slot_link[head_slot];
          end else begin
            // A node unlinked earlier still has its own link, which is used as usual.
            ref_slot = pos - 1;
            succ     = slot_link[ref_slot];
            if (succ >= CAPACITY) st = ST_NOSUCC;
            else slot_link[ref_slot] = slot_link[succ];
          end
        end
        default: begin
          // A read walks from the head, one result per element.
          if (head_slot >= CAPACITY) begin
            owe_result('0, ST_EMPTY, 1'b1);
          end else begin
            cur    = head_slot;
            walked = 0;
            while (cur < CAPACITY && walked < CAPACITY) begin
              succ = slot_link[cur];
              owe_result(slot_value[cur], ST_OK, (succ >= CAPACITY) || (walked + 1 >= CAPACITY));
              walked++;
              cur = succ;
            end
          end
          return;
        end
      endcase
      owe_result('0, st, 1'b1);
    endfunction

    // Compare one emitted result with the oldest one owed.
    function void check_result(logic signed [DATA_W-1:0] value, logic [STATUS_W-1:0] st,
                               logic lst);
      list_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual value %0d status %0d last %0d",
                 $time, value, st, lst);
        mismatch_count++;
        return;
      end
      want = pending_results.pop_front();
      if (value !== want.value) begin
        $display("%0t: value_out mismatch: expected %0d, actual %0d", $time, want.value, value);
        mismatch_count++;
      end
      if (st !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status, st);
        mismatch_count++;
      end
      if (lst !== want.last) begin
        $display("%0t: last mismatch: expected %0d, actual %0d", $time, want.last, lst);
        mismatch_count++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [1:0]               command;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value_in;
  logic                     result_valid;
  logic signed [DATA_W-1:0] value_out;
  logic [STATUS_W-1:0]      status;
  logic                     last;

  linked_list_scoreboard sb;
  int unsigned           quiet_cycles;

  static_linked_list_engine_top #(.CAPACITY(CAPACITY)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .position     (position),
    .value_in     (value_in),
    .result_valid (result_valid),
    .value_out    (value_out),
    .status       (status),
    .last         (last)
  );

  // Free-running 10 ns clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results are checked first, then an accepted request is applied to the mirror.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) sb.check_result(value_out, status, last);
      if (start && !busy) sb.apply_request(cmd_t'(command), position, value_in);
    end
  end

  // Watchdog: too many cycles with neither a request nor a result ends the run.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 sb.pending_results.size());
        $display("[static_linked_list_engine_top] ERROR");
        $finish;
      end
    end
  end

  // Present one request and hold it until the engine takes it.
  task automatic send_request(input cmd_t cmd, input int unsigned pos,
                              input logic [DATA_W-1:0] val);
    @(negedge clk);
    start    = 1'b1;
    command  = cmd;
    position = pos[POS_W-1:0];
    value_in = val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Keep start low for a number of cycles.
  task automatic hold_off(input int unsigned cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Stop sending and wait until every owed result has come back.
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // Random requests: mostly valid reference positions, some head and out-of-range ones.
  task automatic random_requests(input int unsigned count, input int unsigned insert_pct,
                                 input int unsigned read_pct, input int unsigned idle_pct);
    int unsigned      roll;
    int unsigned      pick;
    int unsigned      pos;
    cmd_t             cmd;
    logic [DATA_W-1:0] val;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < insert_pct) cmd = ($urandom_range(1) == 0) ? CMD_INS_HEAD : CMD_INS_AFTER;
      else if (roll < insert_pct + read_pct) cmd = CMD_READ;
      else cmd = CMD_DEL_AFTER;
      pick = $urandom_range(9);
      if (pick < 8 && sb.slot_count > 0) pos = $urandom_range(sb.slot_count, 1);
      else if (pick == 8) pos = 0;
      else pos = $urandom_range(127, 0);
      case ($urandom_range(15))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = 32'hFFFF_FFFF;
        default: val = $urandom;
      endcase
      send_request(cmd, pos, val);
      if ($urandom_range(99) < idle_pct) hold_off($urandom_range(6, 1));
    end
  endtask

  // Main sequence: reset, directed cases, then random phases.
  initial begin
    sb       = new();
    rst      = 1'b1;
    start    = 1'b0;
    command  = CMD_INS_HEAD;
    position = '0;
    value_in = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Operations on an empty list.
    send_request(CMD_READ, 0, 32'h0);
    send_request(CMD_DEL_AFTER, 0, 32'h0);
    send_request(CMD_DEL_AFTER, 1, 32'h0);
    send_request(CMD_INS_AFTER, 0, 32'h1234_5678);
    send_request(CMD_INS_AFTER, 1, 32'h1234_5678);

    // Build a short list with extreme values.
    send_request(CMD_INS_HEAD, 0, 32'h7FFF_FFFF);
    send_request(CMD_INS_HEAD, 127, 32'h8000_0000);
    send_request(CMD_INS_AFTER, 1, 32'hFFFF_FFFF);
    send_request(CMD_INS_AFTER, 3, 32'h0000_0000);
    send_request(CMD_INS_AFTER, 0, 32'h5555_5555);
    send_request(CMD_INS_AFTER, 5, 32'hAAAA_AAAA);
    send_request(CMD_READ, 0, 32'h0);

    // Deletes: no successor, head removal, then a removed node as reference.
    send_request(CMD_DEL_AFTER, 4, 32'h0);
    send_request(CMD_DEL_AFTER, 0, 32'h0);
    send_request(CMD_DEL_AFTER, 2, 32'h0);
    send_request(CMD_READ, 0, 32'h0);
    send_request(CMD_DEL_AFTER, 64, 32'h0);
    send_request(CMD_DEL_AFTER, 127, 32'h0);
    send_request(CMD_DEL_AFTER, 1, 32'h0);
    send_request(CMD_READ, 0, 32'h0);
    hold_off(3);

    // Growth phase that fills every slot, so full inserts follow.
    random_requests(120, 60, 15, 30);
    drain_results();

    // Shrinking phase with many deletes against a full store.
    random_requests(110, 25, 20, 30);
    drain_results();

    // Closing stretch back to back.
    random_requests(40, 30, 20, 0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending_results.size() == 0) begin
      $display("[static_linked_list_engine_top] OK");
    end else begin
      if (sb.pending_results.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, sb.pending_results.size());
      $display("[static_linked_list_engine_top] ERROR");
    end
    $finish;
  end

endmodule
